>>> rtl/core/skf_pkg.sv
// Shared constants, register codes and saturation helper for the scalar Kalman filter.
// Used by skf_mul, skf_div and scalar_kalman_filter; depends on nothing.
`default_nettype none

package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 25;
  localparam int FRAC_W    = 24;
  localparam int MA_W      = 42;
  localparam int MB_W      = 33;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int SH_W      = PROD_W - FRAC_W;
  localparam int MUL_CNT_W = 6;
  localparam int DEN_W     = DATA_W + 1;
  localparam int REM_W     = DATA_W + 2;
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = 5;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TRANSITION_GAIN   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_OBSERVATION_GAIN  = 2'd3;

  localparam logic [DATA_W-1:0] RST_PROCESS_NOISE     = 32'd1678;
  localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE = 32'd4529848;
  localparam logic [DATA_W-1:0] RST_TRANSITION_GAIN   = 32'd16777216;
  localparam logic [DATA_W-1:0] RST_OBSERVATION_GAIN  = 32'd16777216;
  localparam logic [DATA_W-1:0] RST_ESTIMATE          = 32'd65536;
  localparam logic [DATA_W-1:0] RST_COVARIANCE        = 32'd83886080;

  localparam logic [GAIN_W-1:0] ONE_Q24 = 25'd16777216;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [SH_W-1:0] v);
    logic signed [SH_W-1:0] smax;
    logic signed [SH_W-1:0] smin;
    smax = {{(SH_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    smin = {{(SH_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > smax) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < smin) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/skf_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on skf_pkg for operand and product widths.
`default_nettype none

module skf_mul import skf_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [MA_W-1:0]   mcand_in,
  input  wire logic signed [MB_W-1:0]   mplier_in,
  output logic                          done,
  output logic        [PROD_W-1:0]      prod
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MA_W-1:0]      acc_hi;
  logic [MB_W-1:0]      acc_lo;
  logic [MA_W-1:0]      mcand;
  logic                 last;
  logic [MA_W-1:0]      addend;
  logic [MA_W:0]        sum;

  assign last   = (cnt == MUL_CNT_W'(MB_W - 1));
  assign addend = acc_lo[0] ? mcand : '0;

  // sign bit of the multiplier carries negative weight
  always_comb begin
    if (last) begin
      sum = {acc_hi[MA_W-1], acc_hi} - {addend[MA_W-1], addend};
    end else begin
      sum = {acc_hi[MA_W-1], acc_hi} + {addend[MA_W-1], addend};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + MUL_CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_hi <= '0;
      acc_lo <= mplier_in;
      mcand  <= mcand_in;
    end else if (busy) begin
      acc_hi <= sum[MA_W:1];
      acc_lo <= {sum[0], acc_lo[MB_W-1:1]};
    end
  end

  assign prod = {acc_hi, acc_lo};

endmodule

`default_nettype wire

>>> rtl/core/skf_div.sv
// Restoring divider for the gain, one quotient bit per cycle.
// Depends on skf_pkg; numerator never exceeds the divisor.
`default_nettype none

module skf_div import skf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DATA_W-1:0]  num,
  input  wire logic [DEN_W-1:0]   den,
  output logic                    done,
  output logic      [GAIN_W-1:0]  quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W-1:0]     rem;
  logic [DEN_W-1:0]     dvs;
  logic [GAIN_W-1:0]    q;
  logic                 dz;
  logic                 last;
  logic                 ge;
  logic [REM_W-1:0]     diff;
  logic [REM_W-1:0]     rem_next;

  assign last     = (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign ge       = (rem >= {1'b0, dvs});
  assign diff     = rem - {1'b0, dvs};
  assign rem_next = ge ? diff : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {2'b00, num};
      dvs <= den;
      dz  <= (den == '0);
      q   <= '0;
    end else if (busy) begin
      rem <= {rem_next[REM_W-2:0], 1'b0};
      q   <= {q[GAIN_W-2:0], ge};
    end
  end

  // zero divisor yields zero gain
  assign quo = dz ? '0 : q;

endmodule

`default_nettype wire

>>> rtl/core/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: APB register file, step sequencer, result register.
// Depends on skf_pkg, skf_mul and skf_div.
//
// One sample beat in, one result beat (estimate, gain) out. Each step runs four products
// through one bit-serial 33-step multiplier, with the 25-step gain division running beside
// the first of them. result_valid rises as the step leaves ST_FIN, and the next sample can
// be accepted in the cycle after; the four serial products set the length of a step. A
// stalled result holds the step in ST_FIN until the result register frees. sample_stall is
// high from acceptance until the step is finished; a waiting result does not block the next
// sample. Registers sit at byte addresses 0, 4, 8 and 12 (Q, R, A, H); the user must write
// them only while the filter is idle, and the block itself does not enforce this.
`default_nettype none

module scalar_kalman_filter import skf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire logic [DATA_W-1:0]   sample,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic      [DATA_W-1:0]   estimate,
  output logic      [GAIN_W-1:0]   gain
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_MS_AX = 4'd1;
  localparam logic [ST_W-1:0] ST_MW_AX = 4'd2;
  localparam logic [ST_W-1:0] ST_MS_HX = 4'd3;
  localparam logic [ST_W-1:0] ST_MW_HX = 4'd4;
  localparam logic [ST_W-1:0] ST_MS_GE = 4'd5;
  localparam logic [ST_W-1:0] ST_MW_GE = 4'd6;
  localparam logic [ST_W-1:0] ST_MS_PC = 4'd7;
  localparam logic [ST_W-1:0] ST_MW_PC = 4'd8;
  localparam logic [ST_W-1:0] ST_FIN   = 4'd9;

  logic [ST_W-1:0]   state;
  logic [DATA_W-1:0] process_noise;
  logic [DATA_W-1:0] measurement_noise;
  logic [DATA_W-1:0] transition_gain;
  logic [DATA_W-1:0] observation_gain;
  logic [DATA_W-1:0] estimate_reg;
  logic [DATA_W-1:0] covariance_reg;

  logic [DATA_W-1:0] sample_r;
  logic [DATA_W-1:0] pp;
  logic [DATA_W-1:0] xp;
  logic [MA_W-1:0]   innov;
  logic [DATA_W-1:0] est_upd;
  logic [DATA_W-1:0] cov_upd;

  logic              sample_acc;
  logic              cfg_wr;
  logic [DATA_W:0]   pp_sum;
  logic [DATA_W-1:0] pp_next;
  logic [DEN_W-1:0]  den;

  logic              mul_start;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic [SH_W-1:0]   prod_sh;

  logic              div_start;
  logic              div_done;
  logic              div_seen;
  logic [GAIN_W-1:0] div_q;
  logic [GAIN_W-1:0] one_minus_g;
  logic [SH_W-1:0]   upd_sum;
  logic              out_free;

  assign pready       = 1'b1;
  assign cfg_wr       = psel & penable & pwrite & pready;
  assign sample_stall = (state != ST_IDLE);
  assign sample_acc   = sample_valid & ~sample_stall;
  assign out_free     = ~result_valid | ~result_stall;

  assign pp_sum  = {1'b0, covariance_reg} + {1'b0, process_noise};
  assign pp_next = pp_sum[DATA_W] ? {DATA_W{1'b1}} : pp_sum[DATA_W-1:0];
  assign den     = {1'b0, pp} + {1'b0, measurement_noise};

  assign mul_start   = (state == ST_MS_AX) | (state == ST_MS_HX) |
                       ((state == ST_MS_GE) & div_seen) | (state == ST_MS_PC);
  assign div_start   = (state == ST_MS_AX);
  assign one_minus_g = ONE_Q24 - div_q;
  assign prod_sh     = mul_prod[PROD_W-1:FRAC_W];
  assign upd_sum     = {{(SH_W-DATA_W){xp[DATA_W-1]}}, xp} + prod_sh;

  always_comb begin
    unique case (state)
      ST_MS_AX: begin
        mul_a = {{(MA_W-DATA_W){estimate_reg[DATA_W-1]}}, estimate_reg};
        mul_b = {{(MB_W-DATA_W){transition_gain[DATA_W-1]}}, transition_gain};
      end
      ST_MS_HX: begin
        mul_a = {{(MA_W-DATA_W){xp[DATA_W-1]}}, xp};
        mul_b = {{(MB_W-DATA_W){observation_gain[DATA_W-1]}}, observation_gain};
      end
      ST_MS_GE: begin
        mul_a = innov;
        mul_b = {{(MB_W-GAIN_W){1'b0}}, div_q};
      end
      ST_MS_PC: begin
        mul_a = {{(MA_W-DATA_W){1'b0}}, pp};
        mul_b = {{(MB_W-GAIN_W){1'b0}}, one_minus_g};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  skf_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (mul_a),
    .mplier_in (mul_b),
    .done      (mul_done),
    .prod      (mul_prod)
  );

  skf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pp),
    .den   (den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    unique case (paddr[REG_IDX_W+1:2])
      REG_PROCESS_NOISE:     prdata = process_noise;
      REG_MEASUREMENT_NOISE: prdata = measurement_noise;
      REG_TRANSITION_GAIN:   prdata = transition_gain;
      REG_OBSERVATION_GAIN:  prdata = observation_gain;
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= RST_PROCESS_NOISE;
      measurement_noise <= RST_MEASUREMENT_NOISE;
      transition_gain   <= RST_TRANSITION_GAIN;
      observation_gain  <= RST_OBSERVATION_GAIN;
    end else if (cfg_wr) begin
      unique case (paddr[REG_IDX_W+1:2])
        REG_PROCESS_NOISE:     process_noise     <= pwdata;
        REG_MEASUREMENT_NOISE: measurement_noise <= pwdata;
        REG_TRANSITION_GAIN:   transition_gain   <= pwdata;
        REG_OBSERVATION_GAIN:  observation_gain  <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      estimate_reg   <= RST_ESTIMATE;
      covariance_reg <= RST_COVARIANCE;
      result_valid   <= 1'b0;
    end else begin
      if ((state == ST_FIN) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid & ~result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:  if (sample_acc) state <= ST_MS_AX;
        ST_MS_AX: state <= ST_MW_AX;
        ST_MW_AX: if (mul_done) state <= ST_MS_HX;
        ST_MS_HX: state <= ST_MW_HX;
        ST_MW_HX: if (mul_done) state <= ST_MS_GE;
        ST_MS_GE: if (div_seen) state <= ST_MW_GE;
        ST_MW_GE: if (mul_done) state <= ST_MS_PC;
        ST_MS_PC: state <= ST_MW_PC;
        ST_MW_PC: if (mul_done) state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            estimate_reg   <= est_upd;
            covariance_reg <= cov_upd;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      sample_r <= sample;
      pp       <= pp_next;
    end
    if ((state == ST_MW_AX) && mul_done) begin
      xp <= sat32(prod_sh);
    end
    if ((state == ST_MW_HX) && mul_done) begin
      innov <= {{(MA_W-DATA_W){sample_r[DATA_W-1]}}, sample_r} - prod_sh[MA_W-1:0];
    end
    if ((state == ST_MW_GE) && mul_done) begin
      est_upd <= sat32(upd_sum);
    end
    if ((state == ST_MW_PC) && mul_done) begin
      cov_upd <= mul_prod[FRAC_W+DATA_W-1:FRAC_W];
    end
    if ((state == ST_FIN) && out_free) begin
      estimate <= est_upd;
      gain     <= div_q;
    end
  end

  // division always ends well before the gain is needed
  always_ff @(posedge clk) begin
    if (rst) begin
      div_seen <= 1'b0;
    end else if (div_start) begin
      div_seen <= 1'b0;
    end else if (div_done) begin
      div_seen <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> verif/skf_checker.sv
`timescale 1ns / 1ps
// Result checker for scalar_kalman_filter: tracks register writes, predicts each step, compares.
// Depends on skf_pkg for widths, register codes and reset values.
module skf_checker
  import skf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                sample_valid,
  input  logic                sample_stall,
  input  logic [DATA_W-1:0]   sample,
  input  logic                result_valid,
  input  logic                result_stall,
  input  logic [DATA_W-1:0]   estimate,
  input  logic [GAIN_W-1:0]   gain,
  output int unsigned         fail_count,
  output int unsigned         outstanding
);

  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;
  localparam longint COV_MAX = 64'sd4294967295;

  typedef struct packed {
    logic [DATA_W-1:0] estimate;
    logic [GAIN_W-1:0] gain;
  } filter_out_t;

  filter_out_t              filter_out_q[$];
  logic [DATA_W-1:0]        q_noise;
  logic [DATA_W-1:0]        r_noise;
  logic signed [DATA_W-1:0] a_factor;
  logic signed [DATA_W-1:0] h_factor;
  logic signed [DATA_W-1:0] x_state;
  logic [DATA_W-1:0]        p_state;

  function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
    if (v > Q16_MAX) begin
      return Q16_MAX[DATA_W-1:0];
    end else if (v < Q16_MIN) begin
      return Q16_MIN[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  task automatic kalman_update(input logic signed [DATA_W-1:0] meas);
    longint      xp;
    longint      pp;
    longint      den;
    longint      g;
    longint      hx;
    longint      innov;
    longint      corr;
    longint      pn;
    filter_out_t res;
    xp = clamp_q16((longint'(a_factor) * longint'(x_state)) >>> FRAC_W);
    pp = longint'(p_state) + longint'(q_noise);
    if (pp > COV_MAX) begin
      pp = COV_MAX;
    end
    den = pp + longint'(r_noise);
    g = (den == 0) ? 0 : (pp <<< FRAC_W) / den;
    hx = (longint'(h_factor) * xp) >>> FRAC_W;
    innov = longint'(meas) - hx;
    corr = (g * innov) >>> FRAC_W;
    x_state = clamp_q16(xp + corr);
    pn = ((longint'(ONE_Q24) - g) * pp) >>> FRAC_W;
    p_state = pn[DATA_W-1:0];
    res.estimate = x_state;
    res.gain = g[GAIN_W-1:0];
    filter_out_q.push_back(res);
  endtask

  always @(posedge clk) begin
    filter_out_t want;
    if (rst) begin
      q_noise = RST_PROCESS_NOISE;
      r_noise = RST_MEASUREMENT_NOISE;
      a_factor = RST_TRANSITION_GAIN;
      h_factor = RST_OBSERVATION_GAIN;
      x_state = RST_ESTIMATE;
      p_state = RST_COVARIANCE;
      filter_out_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_IDX_W+1:2])
          REG_PROCESS_NOISE:     q_noise = pwdata;
          REG_MEASUREMENT_NOISE: r_noise = pwdata;
          REG_TRANSITION_GAIN:   a_factor = pwdata;
          REG_OBSERVATION_GAIN:  h_factor = pwdata;
          default: ;
        endcase
      end
      // retire the oldest beat before a new sample adds to the queue
      if (result_valid && !result_stall) begin
        if (filter_out_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result beat: estimate %h gain %h", estimate, gain);
          end
          fail_count++;
        end else begin
          want = filter_out_q.pop_front();
          if (estimate !== want.estimate || gain !== want.gain) begin
            if (fail_count < 10) begin
              $display("result mismatch: estimate exp %h got %h, gain exp %h got %h",
                       want.estimate, estimate, want.gain, gain);
            end
            fail_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        kalman_update(sample);
      end
    end
    outstanding <= filter_out_q.size();
  end

endmodule

>>> verif/tb_scalar_kalman_filter.sv
`timescale 1ns / 1ps
// Testbench top for scalar_kalman_filter: clock, reset, register writes, sample and result beats.
// Depends on skf_pkg, the filter RTL and skf_checker, which predicts and compares every result.
module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 550;
  localparam int unsigned CONFIG_SPAN = 110;
  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                sample_valid;
  logic                sample_stall;
  logic [DATA_W-1:0]   sample;
  logic                result_valid;
  logic                result_stall;
  logic [DATA_W-1:0]   estimate;
  logic [GAIN_W-1:0]   gain;

  int unsigned         fail_count;
  int unsigned         outstanding;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int unsigned         quiet_cycles;

  logic [DATA_W-1:0]   corner_vals [5] = '{POS_MAX, NEG_MAX, 32'h0, ALL_ONES, 32'h1};

  scalar_kalman_filter uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .estimate     (estimate),
    .gain         (gain)
  );

  skf_checker filter_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .estimate     (estimate),
    .gain         (gain),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_scalar_kalman_filter: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_filter(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
                                input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] h);
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASUREMENT_NOISE, r);
    write_reg(REG_TRANSITION_GAIN, a);
    write_reg(REG_OBSERVATION_GAIN, h);
  endtask

  // drop valid and hold until every result is back and the step is done
  task automatic wait_idle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || sample_stall);
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] val);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sample_valid <= 1'b1;
    sample <= val;
    do @(posedge clk); while (sample_stall);
  endtask

  function automatic logic [DATA_W-1:0] pick_noise(input int unsigned typical_max);
    case ($urandom_range(5))
      0: return $urandom;
      1: return '0;
      2: return ALL_ONES;
      default: return $urandom_range(0, typical_max);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_factor();
    case ($urandom_range(6))
      0: return $urandom;
      1: return POS_MAX;
      2: return NEG_MAX;
      3: return '0;
      default: return RST_TRANSITION_GAIN + $urandom_range(0, 1 << 22) - (1 << 21);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] noisy_sample(input int level);
    case ($urandom_range(9))
      0: return $urandom;
      1: return corner_vals[$urandom_range(3)];
      default: return level + int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  task automatic run_tracking(input int unsigned count);
    int level;
    level = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % CONFIG_SPAN == 0) begin
        wait_idle();
        program_filter(pick_noise(1 << 20), pick_noise(1 << 26), pick_factor(), pick_factor());
      end
      level = level + int'($urandom_range(0, 4096)) - 2048;
      if (level > (1 << 24)) begin
        level = 1 << 24;
      end else if (level < -(1 << 24)) begin
        level = -(1 << 24);
      end
      send_sample(noisy_sample(level));
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_valid = 1'b0;
    sample = '0;
    send_idle_pct = 15;
    recv_idle_pct = 79;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_vals[i]) begin
      send_sample(corner_vals[i]);
    end
    // covariance and prediction saturate, innovation overflows the estimate
    wait_idle();
    program_filter(ALL_ONES, 32'h0, POS_MAX, NEG_MAX);
    send_sample(POS_MAX);
    send_sample(NEG_MAX);
    send_sample(32'h0001_0000);
    send_sample(POS_MAX);
    // zero noise drives the covariance to zero, then the gain divides by zero
    wait_idle();
    program_filter(32'h0, 32'h0, RST_TRANSITION_GAIN, RST_OBSERVATION_GAIN);
    send_sample(32'h0003_0000);
    send_sample(32'hFFFE_0000);
    send_sample(POS_MAX);
    send_sample(NEG_MAX);
    wait_idle();
    program_filter(RST_PROCESS_NOISE, ALL_ONES, NEG_MAX, POS_MAX);
    send_sample(NEG_MAX);
    send_sample(POS_MAX);
    send_sample(32'h5555_AAAA);
    send_sample(32'hAAAA_5555);

    run_tracking(PHASE_ITEMS);
    wait_idle();
    send_idle_pct = 79;
    recv_idle_pct = 15;
    run_tracking(PHASE_ITEMS);
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_tracking(PHASE_ITEMS);

    wait_idle();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_scalar_kalman_filter: PASS");
    end else begin
      $display("tb_scalar_kalman_filter: FAIL");
    end
    $finish;
  end

endmodule
